@@ src/rnus_pkg.sv @@
// Package: payload structs, queue entry type and fixed constants of the upscaler.
`default_nettype none

package rnus_pkg;

	// Video standard codes
	localparam logic STD_NTSC = 1'b0;
	localparam logic STD_PAL  = 1'b1;

	// Row ratio terms per standard
	localparam logic [3:0] NTSC_NUM = 4'd8;
	localparam logic [3:0] NTSC_DEN = 4'd5;
	localparam logic [3:0] PAL_NUM  = 4'd3;
	localparam logic [3:0] PAL_DEN  = 4'd2;

	// Depth of the queue between front and back
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [15:0] pixel_rgb565;
		logic        frame_start;
	} pixel_t;

	typedef struct packed {
		logic [8:0] out_x;
		logic [8:0] out_y;
		logic [7:0] red8;
		logic [7:0] green8;
		logic [7:0] blue8;
		logic       last;
	} result_t;

	// One classified source pixel waiting for the back end
	typedef struct packed {
		logic [8:0] x_a;
		logic [8:0] x_b;
		logic [8:0] y0;
		logic       dup_x;
		logic       dup_y;
		logic [7:0] red8;
		logic [7:0] green8;
		logic [7:0] blue8;
	} job_t;

endpackage

`default_nettype wire

@@ src/rgb565_nearest_upscale_scatter.sv @@
// Module: top level of the RGB565 nearest-neighbor 1.5x scatter upscaler.
//
//   channel   handshake              payload          direction
//   input     push / full            pixel (pixel_t)  in
//   result    pop / empty            result (result_t) out
//   config    cfg_valid / cfg_ready  cfg_data         in
//
// Each source pixel yields 1, 2 or 4 results (4 for an even column on a duplicated
// row); the back end emits one result per cycle while its output register is free or
// popped. The front accepts one pixel per cycle until the 4-entry queue fills.
// Reset clears counters, queue pointers and output valid; the standard resets to NTSC.
// A stalled result (pop low) holds the output register; the queue keeps taking pixels.
`default_nettype none

module rgb565_nearest_upscale_scatter
	import rnus_pkg::*;
#(
	parameter int SRC_WIDTH  = 256,
	parameter int OUT_WIDTH  = 384,
	parameter int PAL_LINES  = 240,
	parameter int NTSC_LINES = 224
) (
	input  wire  logic    clk,
	input  wire  logic    arst_n,
	input  wire  logic    push,
	output logic          full,
	input  wire  pixel_t  pixel,
	output logic          empty,
	input  wire  logic    pop,
	output result_t       result,
	input  wire  logic    cfg_valid,
	output logic          cfg_ready,
	input  wire  logic    cfg_data
);

	logic video_standard_q;
	logic accept;
	job_t front_job;
	job_t head_job;
	logic head_valid;
	logic head_done;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_standard_q <= STD_NTSC;
		end else if (cfg_valid && cfg_ready) begin
			video_standard_q <= cfg_data;
		end
	end

	rnus_front #(
		.SRC_WIDTH  (SRC_WIDTH),
		.OUT_WIDTH  (OUT_WIDTH),
		.PAL_LINES  (PAL_LINES),
		.NTSC_LINES (NTSC_LINES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.video_standard (video_standard_q),
		.accept         (accept),
		.pixel          (pixel),
		.job            (front_job)
	);

	rnus_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_data  (front_job),
		.full     (full),
		.rd_en    (head_done),
		.rd_data  (head_job),
		.rd_valid (head_valid)
	);

	rnus_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (head_valid),
		.job_done  (head_done),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ src/rnus_fifo.sv @@
// Module: small register queue of classified pixels between front and back.
`default_nettype none

module rnus_fifo
	import rnus_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic wr_en,
	input  wire  job_t wr_data,
	output logic       full,
	input  wire  logic rd_en,
	output job_t       rd_data,
	output logic       rd_valid
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	job_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == CW'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/rnus_front.sv @@
// Module: front end; tracks source position, expands color, classifies each pixel.
`default_nettype none

module rnus_front
	import rnus_pkg::*;
#(
	parameter int SRC_WIDTH  = 256,
	parameter int OUT_WIDTH  = 384,
	parameter int PAL_LINES  = 240,
	parameter int NTSC_LINES = 224
) (
	input  wire  logic   clk,
	input  wire  logic   arst_n,
	input  wire  logic   video_standard,
	input  wire  logic   accept,
	input  wire  pixel_t pixel,
	output job_t         job
);

	localparam int CW      = $clog2(SRC_WIDTH);
	localparam int MAXL    = (PAL_LINES > NTSC_LINES) ? PAL_LINES : NTSC_LINES;
	localparam int RW      = $clog2(MAXL + 1);
	localparam int XR      = $clog2(3 * SRC_WIDTH + 2 * OUT_WIDTH);
	localparam int XW      = (XR > 10) ? XR : 10;
	localparam int XMAX    = OUT_WIDTH - 1;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [8:0]    base_q;
	logic [2:0]    frac_q;

	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;
	logic [RW-1:0] row_inc;
	logic [RW-1:0] lines;
	logic [8:0]    base_cur;
	logic [2:0]    frac_cur;
	logic [2:0]    frac_init;
	logic [3:0]    sum;
	logic [1:0]    carry;
	logic [2:0]    rem;
	logic [XW-1:0] col_ext;
	logic [XW-1:0] x0;
	logic [XW-1:0] x1;
	logic [4:0]    r5;
	logic [5:0]    g6;
	logic [4:0]    b5;

	assign frac_init = (video_standard == STD_PAL) ? 3'(PAL_DEN >> 1) : 3'(NTSC_DEN >> 1);
	assign lines     = (video_standard == STD_PAL) ? RW'(PAL_LINES) : RW'(NTSC_LINES);

	// Frame start restarts the counters ahead of this pixel
	assign col_cur  = pixel.frame_start ? '0 : col_q;
	assign row_cur  = pixel.frame_start ? '0 : row_q;
	assign base_cur = pixel.frame_start ? '0 : base_q;
	assign frac_cur = pixel.frame_start ? frac_init : frac_q;
	assign row_inc  = row_cur + 1'b1;

	// Row accumulator step: sum never exceeds 12, so NTSC quotient by compare, PAL by shift
	always_comb begin
		sum = {1'b0, frac_cur} + ((video_standard == STD_PAL) ? PAL_NUM : NTSC_NUM);
		if (video_standard == STD_PAL) begin
			carry = sum[2:1];
			rem   = {2'b00, sum[0]};
			if (sum[3]) begin
				carry = 2'd3;
			end
		end else begin
			if (sum >= 4'd10) begin
				carry = 2'd2;
				rem   = 3'(sum - 4'd10);
			end else if (sum >= 4'd5) begin
				carry = 2'd1;
				rem   = 3'(sum - 4'd5);
			end else begin
				carry = 2'd0;
				rem   = sum[2:0];
			end
		end
	end

	// Target columns: round(1.5 * col) and the copy to its right, saturated
	assign col_ext = XW'(col_cur);
	assign x0      = (col_ext + (col_ext << 1) + XW'(1)) >> 1;
	assign x1      = x0 + XW'(1);

	// Color expansion by bit replication
	assign r5 = pixel.pixel_rgb565[15:11];
	assign g6 = pixel.pixel_rgb565[10:5];
	assign b5 = pixel.pixel_rgb565[4:0];

	always_comb begin
		job.x_a    = (x0 > XW'(XMAX)) ? 9'(XMAX) : x0[8:0];
		job.x_b    = (x1 > XW'(XMAX)) ? 9'(XMAX) : x1[8:0];
		job.y0     = base_cur + ((video_standard == STD_PAL) ? 9'd0 : 9'd1);
		job.dup_x  = ~col_cur[0];
		job.dup_y  = carry[1];
		job.red8   = {r5, r5[4:2]};
		job.green8 = {g6, g6[5:4]};
		job.blue8  = {b5, b5[4:2]};
	end

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
			frac_q <= 3'(NTSC_DEN >> 1);
		end else if (accept) begin
			if (col_cur == CW'(SRC_WIDTH - 1)) begin
				col_q <= '0;
				if (row_inc >= lines) begin
					row_q  <= '0;
					base_q <= '0;
					frac_q <= frac_init;
				end else begin
					row_q  <= row_inc;
					base_q <= base_cur + 9'(carry);
					frac_q <= rem;
				end
			end else begin
				col_q  <= col_cur + 1'b1;
				row_q  <= row_cur;
				base_q <= base_cur;
				frac_q <= frac_cur;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/rnus_back.sv @@
// Module: back end; walks each queued pixel over its 1, 2 or 4 targets into an output register.
`default_nettype none

module rnus_back
	import rnus_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  job_t job,
	input  wire  logic job_valid,
	output logic       job_done,
	output logic       empty,
	input  wire  logic pop,
	output result_t    result
);

	logic    out_valid_q;
	result_t out_q;
	logic [1:0] step_q;
	logic    cx;
	logic    ry;
	logic    is_last;
	logic    advance;
	result_t res_next;

	assign cx      = step_q[0];
	assign ry      = step_q[1];
	assign is_last = (cx == job.dup_x) && (ry == job.dup_y);
	assign advance = job_valid && (!out_valid_q || pop);
	assign job_done = advance && is_last;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// Current target of the head pixel
	always_comb begin
		res_next.out_x  = cx ? job.x_b : job.x_a;
		res_next.out_y  = job.y0 + 9'(ry);
		res_next.red8   = job.red8;
		res_next.green8 = job.green8;
		res_next.blue8  = job.blue8;
		res_next.last   = is_last;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res_next;
		end
	end

	// Valid flag and row-major step through the copies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 2'b00;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (is_last) begin
					step_q <= 2'b00;
				end else if (!cx && job.dup_x) begin
					step_q <= {ry, 1'b1};
				end else begin
					step_q <= 2'b10;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_rgb565_nearest_upscale_scatter.sv @@
`timescale 1ns / 100ps
// Testbench for the RGB565 1.5x scatter upscaler: directed table, then random runs across a line end.
module tb_rgb565_nearest_upscale_scatter
	import rnus_pkg::*;
();

	localparam int SRC_W       = 256;
	localparam int OUT_W       = 384;
	localparam int LINES_PAL   = 240;
	localparam int LINES_NTSC  = 224;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 16;

	// One row of the directed table: a register write or a pixel request
	typedef struct packed {
		logic    cfg_row;
		logic    std_val;
		pixel_t  px;
		logic    typed;
		result_t first;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	pixel_t  pixel = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_data = 1'b0;

	int push_idle = 0;
	int pop_idle = 0;
	int fails = 0;
	int stall = 0;

	// Predictor copy of the standard and the frame position
	logic       std_sel = STD_NTSC;
	logic [7:0] src_col = '0;
	logic [7:0] src_row = '0;
	logic [8:0] row_pos = '0;
	logic [3:0] row_rem = NTSC_DEN >> 1;
	result_t    scatter_q[$];
	result_t    due;

	dir_row_t plan [19];

	rgb565_nearest_upscale_scatter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pixel(pixel),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void frame_restart();
		src_col = '0;
		src_row = '0;
		row_pos = '0;
		row_rem = ((std_sel == STD_PAL) ? PAL_DEN : NTSC_DEN) >> 1;
	endfunction

	// Expected scatter of one accepted pixel, then advance the frame position
	task automatic scatter_pixel(input pixel_t p, input logic typed, input result_t first);
		logic [4:0] r5, b5;
		logic [5:0] g6;
		logic [9:0] x0, xc;
		logic [8:0] y0;
		logic [3:0] num, den;
		logic [4:0] sum, carry;
		logic       dup_x, dup_y;
		result_t    px;
		int         base, total, k;
		if (p.frame_start)
			frame_restart();
		r5 = p.pixel_rgb565[15:11];
		g6 = p.pixel_rgb565[10:5];
		b5 = p.pixel_rgb565[4:0];
		px.red8 = {r5, r5[4:2]};
		px.green8 = {g6, g6[5:4]};
		px.blue8 = {b5, b5[4:2]};
		x0 = (10'd3 * src_col + 10'd1) >> 1;
		dup_x = ~src_col[0];
		y0 = row_pos + ((std_sel == STD_NTSC) ? 9'd1 : 9'd0);
		num = (std_sel == STD_PAL) ? PAL_NUM : NTSC_NUM;
		den = (std_sel == STD_PAL) ? PAL_DEN : NTSC_DEN;
		sum = row_rem + num;
		carry = sum / den;
		dup_y = carry >= 5'd2;
		base = scatter_q.size();
		total = (dup_y ? 2 : 1) * (dup_x ? 2 : 1);
		k = 0;
		for (int ry = 0; ry <= (dup_y ? 1 : 0); ry++) begin
			for (int cx = 0; cx <= (dup_x ? 1 : 0); cx++) begin
				xc = x0 + 10'(cx);
				if (xc > 10'(OUT_W - 1))
					xc = 10'(OUT_W - 1);
				px.out_x = xc[8:0];
				px.out_y = y0 + 9'(ry);
				px.last = (k == total - 1);
				scatter_q.push_back(px);
				k++;
			end
		end
		if (typed)
			scatter_q[base] = first;
		// End of line moves the row accumulator; end of frame restarts
		if (src_col == SRC_W - 1) begin
			src_col = '0;
			src_row = src_row + 8'd1;
			row_pos = row_pos + 9'(carry);
			row_rem = 4'(sum % den);
			if (src_row >= ((std_sel == STD_PAL) ? LINES_PAL : LINES_NTSC))
				frame_restart();
		end else begin
			src_col = src_col + 8'd1;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_pixel(input pixel_t p, input logic typed = 1'b0,
			input result_t first = '0);
		while ($urandom_range(99) < push_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push  <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
		scatter_pixel(p, typed, first);
		@(negedge clk);
	endtask

	// Wait until every expected result is out, then let the pipe settle
	task automatic drain();
		push <= 1'b0;
		while (scatter_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_standard(input logic v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		std_sel = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random pixel, corner colors now and then; restart_odds 0 never restarts
	function automatic pixel_t random_pixel(input int restart_odds);
		pixel_t p;
		case ($urandom_range(15))
			0: p.pixel_rgb565 = 16'h0000;
			1: p.pixel_rgb565 = 16'hFFFF;
			default: p.pixel_rgb565 = 16'($urandom_range(16'hFFFF));
		endcase
		p.frame_start = (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0);
		return p;
	endfunction

	// No restarts here, so the column count runs on into a line end
	task automatic random_run(input int items, input logic std);
		write_standard(std);
		repeat (items) send_pixel(random_pixel(0));
	endtask

	// Result side: random pop, updated at the falling edge
	always @(negedge clk)
		pop <= ($urandom_range(99) >= pop_idle);

	function automatic void cmp_field(input string name, input logic [8:0] want,
			input logic [8:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fails++;
		end
	endfunction

	// Compare each popped result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (scatter_q.size() == 0) begin
				$error("result with nothing pending: out_x %0d out_y %0d",
					result.out_x, result.out_y);
				fails++;
			end else begin
				due = scatter_q.pop_front();
				cmp_field("out_x", due.out_x, result.out_x);
				cmp_field("out_y", due.out_y, result.out_y);
				cmp_field("red8", 9'(due.red8), 9'(result.red8));
				cmp_field("green8", 9'(due.green8), 9'(result.green8));
				cmp_field("blue8", 9'(due.blue8), 9'(result.blue8));
				cmp_field("last", 9'(due.last), 9'(result.last));
			end
		end
	end

	// Watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall <= 0;
		end else if (stall == STALL_LIMIT) begin
			$display("FAIL rgb565_nearest_upscale_scatter");
			$finish;
		end else begin
			stall <= stall + 1;
		end
	end

	initial begin
		// Directed: colors at the extremes, restarts, standard switches mid-frame
		plan = '{
			'{1'b0, STD_NTSC, '{16'hFFFF, 1'b1}, 1'b1, '{9'd0, 9'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
			'{1'b0, STD_NTSC, '{16'h0000, 1'b0}, 1'b1, '{9'd2, 9'd1, 8'h00, 8'h00, 8'h00, 1'b0}},
			'{1'b0, STD_NTSC, '{16'hF800, 1'b0}, 1'b1, '{9'd3, 9'd1, 8'hFF, 8'h00, 8'h00, 1'b0}},
			'{1'b0, STD_NTSC, '{16'h07E0, 1'b0}, 1'b1, '{9'd5, 9'd1, 8'h00, 8'hFF, 8'h00, 1'b0}},
			'{1'b0, STD_NTSC, '{16'h001F, 1'b0}, 1'b1, '{9'd6, 9'd1, 8'h00, 8'h00, 8'hFF, 1'b0}},
			'{1'b0, STD_NTSC, '{16'h8410, 1'b0}, 1'b1, '{9'd8, 9'd1, 8'h84, 8'h82, 8'h84, 1'b0}},
			'{1'b0, STD_NTSC, '{16'h7BEF, 1'b0}, 1'b1, '{9'd9, 9'd1, 8'h7B, 8'h7D, 8'h7B, 1'b0}},
			'{1'b0, STD_NTSC, '{16'h5555, 1'b0}, 1'b0, '0},
			'{1'b0, STD_NTSC, '{16'hAAAA, 1'b0}, 1'b0, '0},
			'{1'b0, STD_NTSC, '{16'h0821, 1'b1}, 1'b1, '{9'd0, 9'd1, 8'h08, 8'h04, 8'h08, 1'b0}},
			'{1'b0, STD_NTSC, '{16'hFFFF, 1'b0}, 1'b0, '0},
			'{1'b1, STD_PAL,  '0,                1'b0, '0},
			'{1'b0, STD_PAL,  '{16'hFFFF, 1'b1}, 1'b1, '{9'd0, 9'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0}},
			'{1'b0, STD_PAL,  '{16'h0000, 1'b0}, 1'b1, '{9'd2, 9'd0, 8'h00, 8'h00, 8'h00, 1'b0}},
			'{1'b0, STD_PAL,  '{16'h1234, 1'b0}, 1'b0, '0},
			'{1'b1, STD_NTSC, '0,                1'b0, '0},
			'{1'b0, STD_NTSC, '{16'hEDCB, 1'b0}, 1'b0, '0},
			'{1'b0, STD_NTSC, '{16'h0000, 1'b1}, 1'b1, '{9'd0, 9'd1, 8'h00, 8'h00, 8'h00, 1'b0}},
			'{1'b0, STD_NTSC, '{16'hFFFF, 1'b0}, 1'b0, '0}
		};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_idle = 29;
		pop_idle = 68;
		foreach (plan[i]) begin
			if (plan[i].cfg_row)
				write_standard(plan[i].std_val);
			else
				send_pixel(plan[i].px, plan[i].typed, plan[i].first);
		end
		random_run(100, STD_PAL);

		push_idle = 68;
		pop_idle = 29;
		random_run(100, STD_NTSC);

		// The line end falls in this run, with the remainder left from NTSC
		push_idle = 0;
		pop_idle = 0;
		random_run(95, STD_PAL);
		drain();

		if (fails == 0 && scatter_q.size() == 0)
			$display("PASS rgb565_nearest_upscale_scatter");
		else
			$display("FAIL rgb565_nearest_upscale_scatter");
		$finish;
	end

endmodule
